@@ hw/rtl/tpmd_pkg.sv @@
// Two-tone pilot mode detector: shared constants, widths and types.
// Used by every module of the detector; no dependencies.
package tpmd_pkg;

    localparam int NUM_BINS    = 512;
    localparam int WINDOW_LEN  = 3;
    localparam int SAMPLE_BITS = 16;

    localparam int HALF_WIN = (WINDOW_LEN - 1) / 2;
    localparam int D_RAW    = NUM_BINS - 2 * WINDOW_LEN;
    localparam int D_VAL    = (D_RAW > 0) ? D_RAW : 1;
    localparam int LEFT_K   = 256 * D_VAL;

    localparam int PILOT_W = 9;
    localparam int THR_W   = 16;
    localparam int NF_W    = 16;
    localparam int CFG_W   = 16;
    localparam int ADDR_W  = 3;
    localparam int CODE_W  = 2;
    localparam int NUM_WIN = 4;

    localparam int BIN_W    = $clog2(NUM_BINS);
    localparam int EXT_W    = ((BIN_W > PILOT_W) ? BIN_W : PILOT_W) + 4;
    localparam int ENERGY_W = 2 * SAMPLE_BITS;
    localparam int TOT_W    = 41;
    localparam int WIN_W    = 34;
    localparam int P_W      = WIN_W + 1;
    localparam int B_W      = TOT_W + 1;
    localparam int B_LO_W   = (B_W + 1) / 2;
    localparam int B_HI_W   = B_W - B_LO_W;
    localparam int A_W      = THR_W + $clog2(2 * WINDOW_LEN + 1);
    localparam int NFD_W    = NF_W + $clog2(D_VAL + 1);
    localparam int LEFT_W   = P_W + $clog2(LEFT_K + 1);
    localparam int PROD_W   = A_W + B_W;
    localparam int CMP_W    = (PROD_W > LEFT_W) ? PROD_W : LEFT_W;

    // register indexes
    localparam logic [ADDR_W-1:0] REG_M2_PILOT_A = 3'd0;
    localparam logic [ADDR_W-1:0] REG_M2_PILOT_B = 3'd1;
    localparam logic [ADDR_W-1:0] REG_M1_PILOT_A = 3'd2;
    localparam logic [ADDR_W-1:0] REG_M1_PILOT_B = 3'd3;
    localparam logic [ADDR_W-1:0] REG_THRESHOLD  = 3'd4;
    localparam logic [ADDR_W-1:0] REG_NOISE_FLR  = 3'd5;

    localparam logic [PILOT_W-1:0] PILOT_RST = 9'd1;
    localparam logic [THR_W-1:0]   THR_RST   = 16'd2560;
    localparam logic [NF_W-1:0]    NF_RST    = 16'd1;

    // window slots: mode two a, mode two b, mode one a, mode one b
    typedef struct packed {
        logic [NUM_WIN-1:0][PILOT_W-1:0] pilot;
        logic [THR_W-1:0]                threshold;
        logic [NF_W-1:0]                 noise_floor;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic accumulate;
        logic dec_sum;
        logic dec_mix;
        logic dec_lo;
        logic dec_hi;
        logic dec_cmp;
        logic mode_sel;   // 0: mode one, 1: mode two
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last_bin;
    } dp_status_t;

endpackage

@@ hw/rtl/tpmd_cfg.sv @@
// Configuration register file of the pilot mode detector.
// Depends on tpmd_pkg for register indexes, reset values and cfg_t.
module tpmd_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [tpmd_pkg::ADDR_W-1:0]   cfg_addr,
    input  logic [tpmd_pkg::CFG_W-1:0]    cfg_wdata,
    output tpmd_pkg::cfg_t                cfg
);
    import tpmd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_M2_PILOT_A: cfg_next.pilot[0] = cfg_wdata[PILOT_W-1:0];
                REG_M2_PILOT_B: cfg_next.pilot[1] = cfg_wdata[PILOT_W-1:0];
                REG_M1_PILOT_A: cfg_next.pilot[2] = cfg_wdata[PILOT_W-1:0];
                REG_M1_PILOT_B: cfg_next.pilot[3] = cfg_wdata[PILOT_W-1:0];
                REG_THRESHOLD:  cfg_next.threshold = cfg_wdata[THR_W-1:0];
                REG_NOISE_FLR:  cfg_next.noise_floor = cfg_wdata[NF_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pilot       <= {NUM_WIN{PILOT_RST}};
            cfg_reg.threshold   <= THR_RST;
            cfg_reg.noise_floor <= NF_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/tpmd_dp.sv @@
// Datapath of the pilot mode detector: bin energy, accumulators and the
// division-free decision unit. Depends on tpmd_pkg; driven by tpmd_ctrl.
module tpmd_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  tpmd_pkg::cfg_t                       cfg,
    input  tpmd_pkg::ctrl_cmd_t                  cmd,
    output tpmd_pkg::dp_status_t                 status,
    input  logic signed [tpmd_pkg::SAMPLE_BITS-1:0] s_bin_real,
    input  logic signed [tpmd_pkg::SAMPLE_BITS-1:0] s_bin_imag,
    input  logic                                 s_last_bin,
    output logic [tpmd_pkg::CODE_W-1:0]          m_detect_code
);
    import tpmd_pkg::*;

    logic signed [ENERGY_W-1:0] re_prod;
    logic signed [ENERGY_W-1:0] im_prod;
    logic [ENERGY_W-1:0] re_sq_reg;
    logic [ENERGY_W-1:0] im_sq_reg;
    logic                last_reg;

    logic [BIN_W-1:0]                bin_index_reg, bin_index_next;
    logic [TOT_W-1:0]                total_reg, total_next;
    logic [NUM_WIN-1:0][WIN_W-1:0]   win_reg, win_next;

    logic [ENERGY_W:0]   energy;
    logic [TOT_W:0]      total_sum;
    logic [WIN_W:0]      win_sum [NUM_WIN];
    logic [NUM_WIN-1:0]  in_win;
    logic [EXT_W-1:0]    idx_ext;

    logic [P_W-1:0]     p_reg;
    logic [A_W-1:0]     a_reg;
    logic [NFD_W-1:0]   nfd_reg;
    logic [B_W-1:0]     b_reg;
    logic [LEFT_W-1:0]  left_reg;
    logic [A_W+B_LO_W-1:0] prod_lo_reg;
    logic [A_W+B_HI_W-1:0] prod_hi_reg;
    logic [1:0]         found_reg;
    logic [CODE_W-1:0]  code_reg;

    logic [WIN_W-1:0]   win_a, win_b;
    logic [TOT_W-1:0]   q_val;
    logic [CMP_W-1:0]   ab_full;
    logic               found_now;

    assign re_prod = s_bin_real * s_bin_real;
    assign im_prod = s_bin_imag * s_bin_imag;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            re_sq_reg <= re_prod;
            im_sq_reg <= im_prod;
            last_reg  <= s_last_bin;
        end
    end

    assign energy    = {1'b0, re_sq_reg} + {1'b0, im_sq_reg};
    assign total_sum = {1'b0, total_reg} + (TOT_W + 1)'(energy);
    assign idx_ext   = EXT_W'(bin_index_reg);

    always_comb begin
        for (int i = 0; i < NUM_WIN; i++) begin
            in_win[i] = (idx_ext + EXT_W'(HALF_WIN) >= EXT_W'(cfg.pilot[i])) &&
                        (idx_ext <= EXT_W'(cfg.pilot[i]) + EXT_W'(HALF_WIN));
            win_sum[i] = {1'b0, win_reg[i]} + (WIN_W + 1)'(energy);
        end
    end

    always_comb begin
        bin_index_next = bin_index_reg;
        total_next     = total_reg;
        win_next       = win_reg;
        if (cmd.load_out) begin
            bin_index_next = '0;
            total_next     = '0;
            win_next       = '0;
        end else if (cmd.accumulate) begin
            if (bin_index_reg == BIN_W'(NUM_BINS - 1))
                bin_index_next = '0;
            else
                bin_index_next = bin_index_reg + 1'b1;
            total_next = total_sum[TOT_W] ? {TOT_W{1'b1}} : total_sum[TOT_W-1:0];
            for (int i = 0; i < NUM_WIN; i++) begin
                if (in_win[i])
                    win_next[i] = win_sum[i][WIN_W] ? {WIN_W{1'b1}} : win_sum[i][WIN_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_index_reg <= '0;
            total_reg     <= '0;
            win_reg       <= '0;
        end else begin
            bin_index_reg <= bin_index_next;
            total_reg     <= total_next;
            win_reg       <= win_next;
        end
    end

    // decision: P*256*D > 2W*thr * (Q + nf*D), one mode per pass
    assign win_a = cmd.mode_sel ? win_reg[0] : win_reg[2];
    assign win_b = cmd.mode_sel ? win_reg[1] : win_reg[3];
    assign q_val = (total_reg > TOT_W'(p_reg)) ? total_reg - TOT_W'(p_reg) : '0;
    assign ab_full = (CMP_W'(prod_hi_reg) << B_LO_W) + CMP_W'(prod_lo_reg);
    assign found_now = CMP_W'(left_reg) > ab_full;

    always_ff @(posedge aclk) begin
        if (cmd.dec_sum) begin
            p_reg   <= P_W'(win_a) + P_W'(win_b);
            a_reg   <= A_W'(cfg.threshold) * A_W'(2 * WINDOW_LEN);
            nfd_reg <= NFD_W'(cfg.noise_floor) * NFD_W'(D_VAL);
        end
        if (cmd.dec_mix) begin
            b_reg    <= B_W'(q_val) + B_W'(nfd_reg);
            left_reg <= LEFT_W'(p_reg) * LEFT_W'(LEFT_K);
        end
        if (cmd.dec_lo)
            prod_lo_reg <= (A_W + B_LO_W)'(a_reg) * (A_W + B_LO_W)'(b_reg[B_LO_W-1:0]);
        if (cmd.dec_hi)
            prod_hi_reg <= (A_W + B_HI_W)'(a_reg) * (A_W + B_HI_W)'(b_reg[B_W-1:B_LO_W]);
        if (cmd.dec_cmp)
            found_reg[cmd.mode_sel] <= found_now;
        if (cmd.load_out)
            code_reg <= (total_reg != '0) ? found_reg : '0;
    end

    assign status.last_bin = last_reg;
    assign m_detect_code   = code_reg;

    for (genvar g = 0; g < NUM_WIN; g++) begin : g_win_chk
        assert property (@(posedge aclk) disable iff (!aresetn)
            TOT_W'(win_reg[g]) <= total_reg)
            else $error("window energy exceeds total energy");
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> (total_reg == '0) && (bin_index_reg == '0))
        else $error("accumulators not cleared after result");

endmodule

@@ hw/rtl/tpmd_ctrl.sv @@
// Controller of the pilot mode detector: input handshake, decision sequence
// and output register control. Depends on tpmd_pkg; commands tpmd_dp.
module tpmd_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  tpmd_pkg::dp_status_t  status,
    output tpmd_pkg::ctrl_cmd_t   cmd
);
    import tpmd_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ACC  = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_MIX  = 3'd3;
    localparam logic [2:0] ST_LO   = 3'd4;
    localparam logic [2:0] ST_HI   = 3'd5;
    localparam logic [2:0] ST_CMP  = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       mode_sel_reg, mode_sel_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        state_next    = state_reg;
        mode_sel_next = mode_sel_reg;
        cmd           = '0;
        cmd.mode_sel  = mode_sel_reg;
        s_ready       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_ACC;
                end
            end
            ST_ACC: begin
                cmd.accumulate = 1'b1;
                mode_sel_next  = 1'b0;
                state_next     = status.last_bin ? ST_SUM : ST_IDLE;
            end
            ST_SUM: begin
                cmd.dec_sum = 1'b1;
                state_next  = ST_MIX;
            end
            ST_MIX: begin
                cmd.dec_mix = 1'b1;
                state_next  = ST_LO;
            end
            ST_LO: begin
                cmd.dec_lo = 1'b1;
                state_next = ST_HI;
            end
            ST_HI: begin
                cmd.dec_hi = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                cmd.dec_cmp = 1'b1;
                if (mode_sel_reg) begin
                    state_next = ST_DONE;
                end else begin
                    mode_sel_next = 1'b1;
                    state_next    = ST_SUM;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out)
            m_valid_next = 1'b1;
        else if (m_ready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mode_sel_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mode_sel_reg <= mode_sel_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ACC && status.last_bin) |=> (state_reg == ST_SUM && !mode_sel_reg))
        else $error("decision did not start with mode one");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP && !mode_sel_reg) |=> (state_reg == ST_SUM && mode_sel_reg))
        else $error("mode two pass skipped");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> (m_valid && state_reg == ST_IDLE))
        else $error("result not presented after load");

endmodule

@@ hw/rtl/two_tone_pilot_mode_detector.sv @@
// Top level of the two-tone pilot start-mode detector.
// Depends on tpmd_pkg, tpmd_cfg, tpmd_ctrl and tpmd_dp.
//
//   Channel | Ports                                         | Direction
//   input   | s_valid s_ready s_bin_real s_bin_imag s_last_bin | in, one bin per item
//   result  | m_valid m_ready m_detect_code                 | out, one item per symbol
//   config  | cfg_wr_en cfg_addr cfg_wdata                  | in, write only
//
// Each bin is captured with squaring, then added to the accumulators; no new bin
// is taken before that. The last bin starts two passes of the shared decision unit
// (sum, noise mix, two half products of the 19x42 threshold product, compare).
// The result sits in an output register; a new symbol may start while it waits,
// and only the next result load stalls on m_ready. Reset is synchronous, clears
// the accumulators and loads the register reset values; no clearing pass.
module two_tone_pilot_mode_detector (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic signed [tpmd_pkg::SAMPLE_BITS-1:0]  s_bin_real,
    input  logic signed [tpmd_pkg::SAMPLE_BITS-1:0]  s_bin_imag,
    input  logic                                     s_last_bin,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic [tpmd_pkg::CODE_W-1:0]              m_detect_code,
    input  logic                                     cfg_wr_en,
    input  logic [tpmd_pkg::ADDR_W-1:0]              cfg_addr,
    input  logic [tpmd_pkg::CFG_W-1:0]               cfg_wdata
);
    import tpmd_pkg::*;

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    tpmd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tpmd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tpmd_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .cmd           (cmd),
        .status        (status),
        .s_bin_real    (s_bin_real),
        .s_bin_imag    (s_bin_imag),
        .s_last_bin    (s_last_bin),
        .m_detect_code (m_detect_code)
    );

endmodule

@@ verif/two_tone_pilot_mode_detector_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for two_tone_pilot_mode_detector: directed bins, then random symbols.
// Depends on tpmd_pkg and the detector RTL; predicts each detect code and checks it in order.
module two_tone_pilot_mode_detector_tb;
    import tpmd_pkg::*;

    localparam logic [CODE_W-1:0] CODE_NONE     = 2'd0;
    localparam logic [CODE_W-1:0] CODE_MODE_ONE = 2'd1;
    localparam logic [CODE_W-1:0] CODE_MODE_TWO = 2'd2;
    localparam logic [CODE_W-1:0] CODE_BOTH     = 2'd3;

    localparam int          REACH         = (WINDOW_LEN - 1) / 2;
    localparam logic [63:0] SPAN          = (NUM_BINS - 2 * WINDOW_LEN > 0) ?
                                            64'(NUM_BINS - 2 * WINDOW_LEN) : 64'd1;
    localparam logic [63:0] TOTAL_CEIL    = (64'd1 << TOT_W) - 64'd1;
    localparam logic [63:0] WIN_CEIL      = (64'd1 << WIN_W) - 64'd1;
    localparam int          SETTLE_CYCLES = 20;
    localparam int          TAIL_CYCLES   = 30;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          PHASE_ITEMS   = 50;
    localparam int          NUM_PHASES    = 8;
    localparam int          PILOT_LO      = 1;
    localparam int          PILOT_HI      = 510;
    localparam int          IDLE_PLAN [4]  = '{0, 81, 0, 20};
    localparam int          STALL_PLAN [4] = '{0, 0, 81, 20};

    typedef struct packed {
        logic [1:0]             stage;
        logic [SAMPLE_BITS-1:0] re;
        logic [SAMPLE_BITS-1:0] im;
        logic                   last;
        logic                   typed;
        logic [CODE_W-1:0]      code;
    } bin_row_t;

    // stage 0: reset settings, stage 1: zero threshold, stage 2: maximum threshold and floor
    localparam bin_row_t BIN_ROWS [0:21] = '{
        '{2'd0, 16'h0000, 16'h0000, 1'b1, 1'b1, CODE_NONE},      // zero total energy
        '{2'd0, 16'h8000, 16'h8000, 1'b1, 1'b1, CODE_BOTH},      // edge window, overlap
        '{2'd0, 16'h0000, 16'h0000, 1'b0, 1'b0, CODE_NONE},
        '{2'd0, 16'h0000, 16'h0000, 1'b0, 1'b0, CODE_NONE},
        '{2'd0, 16'h0000, 16'h0000, 1'b0, 1'b0, CODE_NONE},
        '{2'd0, 16'h7fff, 16'h8000, 1'b1, 1'b1, CODE_NONE},      // energy outside windows only
        '{2'd0, 16'h0001, 16'h0000, 1'b0, 1'b0, CODE_NONE},
        '{2'd0, 16'h0000, 16'hffff, 1'b0, 1'b0, CODE_NONE},
        '{2'd0, 16'h7fff, 16'h7fff, 1'b1, 1'b0, CODE_NONE},
        '{2'd0, 16'h0000, 16'h0001, 1'b1, 1'b0, CODE_NONE},
        '{2'd1, 16'h0000, 16'h0000, 1'b0, 1'b0, CODE_NONE},
        '{2'd1, 16'h0000, 16'h0000, 1'b0, 1'b0, CODE_NONE},
        '{2'd1, 16'h0000, 16'h0000, 1'b0, 1'b0, CODE_NONE},
        '{2'd1, 16'h0000, 16'h0000, 1'b0, 1'b0, CODE_NONE},
        '{2'd1, 16'h0000, 16'h0000, 1'b0, 1'b0, CODE_NONE},
        '{2'd1, 16'h0000, 16'h0000, 1'b0, 1'b0, CODE_NONE},
        '{2'd1, 16'h0064, 16'hff9c, 1'b1, 1'b1, CODE_MODE_TWO},  // bin in both mode-two windows
        '{2'd1, 16'h0000, 16'h0000, 1'b0, 1'b0, CODE_NONE},
        '{2'd1, 16'h0005, 16'h0005, 1'b1, 1'b1, CODE_MODE_ONE},
        '{2'd2, 16'h0000, 16'h0000, 1'b0, 1'b0, CODE_NONE},
        '{2'd2, 16'h8000, 16'h8000, 1'b0, 1'b0, CODE_NONE},
        '{2'd2, 16'h7fff, 16'h7fff, 1'b1, 1'b0, CODE_NONE}
    };

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic signed [SAMPLE_BITS-1:0] s_bin_real;
    logic signed [SAMPLE_BITS-1:0] s_bin_imag;
    logic                          s_last_bin;
    logic                          m_valid;
    logic                          m_ready;
    logic [CODE_W-1:0]             m_detect_code;
    logic                          cfg_wr_en;
    logic [ADDR_W-1:0]             cfg_addr;
    logic [CFG_W-1:0]              cfg_wdata;

    // detector model state
    cfg_t              live_cfg;
    logic [BIN_W-1:0]  bin_pos;
    logic [63:0]       energy_sum;
    logic [63:0]       win_sum [NUM_WIN];
    logic [CODE_W-1:0] code_queue [$];

    logic [CODE_W-1:0] want_code;
    int                send_idle_pct;
    int                recv_stall_pct;
    int                hold_len;
    int                fail_count;
    int                cycle_count;

    two_tone_pilot_mode_detector uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_bin_real    (s_bin_real),
        .s_bin_imag    (s_bin_imag),
        .s_last_bin    (s_last_bin),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_detect_code (m_detect_code),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    function automatic cfg_t make_cfg(int m2a, int m2b, int m1a, int m1b, int thr, int nf);
        cfg_t c;
        c.pilot[REG_M2_PILOT_A] = PILOT_W'(m2a);
        c.pilot[REG_M2_PILOT_B] = PILOT_W'(m2b);
        c.pilot[REG_M1_PILOT_A] = PILOT_W'(m1a);
        c.pilot[REG_M1_PILOT_B] = PILOT_W'(m1b);
        c.threshold   = THR_W'(thr);
        c.noise_floor = NF_W'(nf);
        return c;
    endfunction

    function automatic int pick_pilot();
        return ($urandom_range(3) != 0) ? $urandom_range(1, 40) : $urandom_range(PILOT_LO, PILOT_HI);
    endfunction

    function automatic bit in_pilot_window(int slot);
        int offset;
        offset = int'(bin_pos) - int'(live_cfg.pilot[slot]);
        return offset >= -REACH && offset <= REACH;
    endfunction

    function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b, logic [63:0] ceil);
        logic [63:0] s;
        s = a + b;
        return (s > ceil) ? ceil : s;
    endfunction

    // pilot * 256 * D > threshold * 2W * (noise + floor * D), cross-multiplied
    function automatic bit mode_present(logic [63:0] wa, logic [63:0] wb);
        logic [63:0]  pilot;
        logic [63:0]  noise;
        logic [63:0]  lhs;
        logic [63:0]  gain;
        logic [63:0]  base;
        logic [127:0] rhs;
        pilot = wa + wb;
        noise = (energy_sum > pilot) ? energy_sum - pilot : 64'd0;
        lhs   = pilot * 64'd256 * SPAN;
        gain  = 64'(live_cfg.threshold) * 64'(2 * WINDOW_LEN);
        base  = noise + 64'(live_cfg.noise_floor) * SPAN;
        rhs   = 128'(gain) * 128'(base);
        if (rhs[127:64] != 64'd0)
            return 1'b0;
        return lhs > rhs[63:0];
    endfunction

    // returns the detect code on the last bin, -1 otherwise
    function automatic int absorb_bin(logic signed [SAMPLE_BITS-1:0] re,
                                      logic signed [SAMPLE_BITS-1:0] im, logic last);
        logic [63:0] e;
        int          code;
        e = 64'(longint'(re) * longint'(re)) + 64'(longint'(im) * longint'(im));
        energy_sum = sat_sum(energy_sum, e, TOTAL_CEIL);
        for (int w = 0; w < NUM_WIN; w++) begin
            if (in_pilot_window(w))
                win_sum[w] = sat_sum(win_sum[w], e, WIN_CEIL);
        end
        bin_pos = BIN_W'((int'(bin_pos) + 1) % NUM_BINS);
        if (!last)
            return -1;
        code = CODE_NONE;
        if (energy_sum != 64'd0) begin
            if (mode_present(win_sum[REG_M1_PILOT_A], win_sum[REG_M1_PILOT_B]))
                code = code | CODE_MODE_ONE;
            if (mode_present(win_sum[REG_M2_PILOT_A], win_sum[REG_M2_PILOT_B]))
                code = code | CODE_MODE_TWO;
        end
        bin_pos    = '0;
        energy_sum = 64'd0;
        for (int w = 0; w < NUM_WIN; w++)
            win_sum[w] = 64'd0;
        return code;
    endfunction

    // entered and left at a falling edge with nothing driven yet in that step
    task automatic send_bin(logic signed [SAMPLE_BITS-1:0] re, logic signed [SAMPLE_BITS-1:0] im,
                            logic last, logic typed, logic [CODE_W-1:0] typed_code);
        int code;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_bin_real <= re;
        s_bin_imag <= im;
        s_last_bin <= last;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        code = absorb_bin(re, im, last);
        if (code >= 0)
            code_queue.push_back(typed ? typed_code : code[CODE_W-1:0]);
        @(negedge aclk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(bit hot, int amp);
        int roll;
        roll = $urandom_range(99);
        if (roll < (hot ? 80 : 15))
            return SAMPLE_BITS'($urandom);
        if (!hot && roll < 40)
            return '0;
        return SAMPLE_BITS'(int'($urandom_range(0, 2 * amp)) - amp);
    endfunction

    task automatic send_symbol(int len);
        int amp;
        bit hot;
        amp = $urandom_range(0, 3000);
        for (int k = 0; k < len; k++) begin
            hot = 1'b0;
            for (int w = 0; w < NUM_WIN; w++)
                hot = hot | in_pilot_window(w);
            send_bin(pick_sample(hot, amp), pick_sample(hot, amp), k == len - 1, 1'b0, CODE_NONE);
        end
    endtask

    task automatic drain_results(int extra);
        s_valid <= 1'b0;
        @(negedge aclk);
        while (code_queue.size() != 0)
            @(negedge aclk);
        repeat (extra) @(negedge aclk);
    endtask

    task automatic put_reg(logic [ADDR_W-1:0] addr, logic [CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(negedge aclk);
    endtask

    task automatic load_settings(cfg_t c);
        put_reg(REG_M2_PILOT_A, CFG_W'(c.pilot[REG_M2_PILOT_A]));
        put_reg(REG_M2_PILOT_B, CFG_W'(c.pilot[REG_M2_PILOT_B]));
        put_reg(REG_M1_PILOT_A, CFG_W'(c.pilot[REG_M1_PILOT_A]));
        put_reg(REG_M1_PILOT_B, CFG_W'(c.pilot[REG_M1_PILOT_B]));
        put_reg(REG_THRESHOLD, c.threshold);
        put_reg(REG_NOISE_FLR, c.noise_floor);
        cfg_wr_en <= 1'b0;
        live_cfg = c;
    endtask

    always @(negedge aclk) begin
        if (hold_len > 0) begin
            m_ready <= 1'b0;
            hold_len = hold_len - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (code_queue.size() == 0) begin
                $error("unexpected item: detect_code %0d", m_detect_code);
                fail_count++;
            end else begin
                want_code = code_queue.pop_front();
                if (m_detect_code !== want_code) begin
                    $error("detect_code: expected %0d, got %0d", want_code, m_detect_code);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("two_tone_pilot_mode_detector_tb failed");
            $finish;
        end
    end

    initial begin
        cfg_t phase_cfg;
        int   stage;
        int   phase_items;
        int   len;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_bin_real     = '0;
        s_bin_imag     = '0;
        s_last_bin     = 1'b0;
        m_ready        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_addr       = '0;
        cfg_wdata      = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_len       = 0;
        fail_count     = 0;
        cycle_count    = 0;
        live_cfg   = make_cfg(PILOT_RST, PILOT_RST, PILOT_RST, PILOT_RST, THR_RST, NF_RST);
        bin_pos    = '0;
        energy_sum = 64'd0;
        for (int w = 0; w < NUM_WIN; w++)
            win_sum[w] = 64'd0;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        stage = 0;
        foreach (BIN_ROWS[r]) begin
            if (BIN_ROWS[r].stage != stage) begin
                stage = BIN_ROWS[r].stage;
                drain_results(SETTLE_CYCLES);
                load_settings((stage == 1) ? make_cfg(5, 7, 2, PILOT_HI, 0, 1)
                                           : make_cfg(5, 7, 2, PILOT_HI, 65535, 65535));
            end
            send_bin(BIN_ROWS[r].re, BIN_ROWS[r].im, BIN_ROWS[r].last,
                     BIN_ROWS[r].typed, BIN_ROWS[r].code);
        end

        // index wrap past NUM_BINS, total and the windows at pilots 2, 5 and 7 saturate
        for (int k = 0; k < 1100; k++)
            send_bin(16'sh8000, 16'sh8000, k == 1099, 1'b0, CODE_NONE);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain_results(SETTLE_CYCLES);
            case (phase)
                0: phase_cfg = make_cfg(PILOT_LO, PILOT_LO, PILOT_LO, PILOT_LO, 0, 0);
                1: phase_cfg = make_cfg(PILOT_HI, PILOT_HI, PILOT_HI, PILOT_HI, 65535, 65535);
                default: begin
                    phase_cfg = make_cfg(pick_pilot(), pick_pilot(), pick_pilot(), pick_pilot(),
                        ($urandom_range(1) != 0) ? $urandom_range(0, 4096) : $urandom_range(0, 65535),
                        ($urandom_range(1) != 0) ? $urandom_range(0, 16) : $urandom_range(0, 65535));
                end
            endcase
            load_settings(phase_cfg);
            send_idle_pct  = IDLE_PLAN[phase % 4];
            recv_stall_pct = STALL_PLAN[phase % 4];
            phase_items    = 0;
            if (phase == 0) begin
                // result side held off while short symbols keep coming
                hold_len = 400;
                repeat (60) send_symbol(2);
                phase_items = 120;
            end
            while (phase_items < PHASE_ITEMS) begin
                len = ($urandom_range(99) < 3) ? $urandom_range(500, 530) : $urandom_range(1, 48);
                send_symbol(len);
                phase_items += len;
                if ($urandom_range(99) < 5)
                    drain_results(0);
            end
        end

        drain_results(TAIL_CYCLES);
        if (fail_count == 0)
            $display("two_tone_pilot_mode_detector_tb passed");
        else
            $display("two_tone_pilot_mode_detector_tb failed");
        $finish;
    end

endmodule
